/* src/sfu_pkg.sv */
// Package: widths, register codes and shared types of the spring force unit.
package sfu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int D_W       = 33;                   // |delta| magnitude
	localparam int SQ_W      = 2 * D_W;              // squared length
	localparam int ROOT_W    = D_W;                  // length
	localparam int REM_W     = ROOT_W + 2;           // root remainder
	localparam int K_W       = 31;
	localparam int DABS_W    = ROOT_W;               // |length - rest|
	localparam int DL        = (DABS_W + 1) / 2;     // split of |disp|
	localparam int PK_W      = K_W + DABS_W;
	localparam int MAG_W     = PK_W - FRAC_BITS;
	localparam int U_W       = FRAC_BITS + 1;        // unit vector component
	localparam int DIVN_W    = D_W + FRAC_BITS;
	localparam int ML        = MAG_W / 2;            // split of magnitude
	localparam int P_W       = MAG_W + U_W;
	localparam int FW        = P_W - FRAC_BITS;
	localparam int SQ_ST     = ROOT_W;               // root stages
	localparam int DV_ST     = U_W;                  // divide stages
	localparam int TINY_LEN  = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = ADDR_W - 2;

	localparam logic [IDX_W-1:0] REG_K    = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_REST = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_MODE = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_AX   = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_AY   = IDX_W'(4);

	localparam logic [1:0] MODE_PAIR   = 2'd0;
	localparam logic [1:0] MODE_ANCHOR = 2'd1;
	localparam logic [1:0] MODE_BUNGEE = 2'd2;

	typedef struct packed {
		logic [K_W-1:0] k;
		logic [K_W-1:0] rest;
		logic [1:0]     mode;
		logic [31:0]    anchor_x;
		logic [31:0]    anchor_y;
	} cfg_t;

	typedef struct packed {
		logic [D_W-1:0] ax;
		logic [D_W-1:0] ay;
		logic           sx;
		logic           sy;
		logic [K_W-1:0] k;
		logic [K_W-1:0] rest;
		logic           bungee;
	} geo_t;

	typedef struct packed {
		logic [D_W-1:0]    ax;
		logic [D_W-1:0]    ay;
		logic [ROOT_W-1:0] len;
		logic [DABS_W-1:0] dabs;
		logic [K_W-1:0]    k;
		logic              sx;
		logic              sy;
		logic              dneg;
		logic              skip;
	} chk_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             dneg;
		logic             sx;
		logic             sy;
		logic             skip;
	} frc_t;

endpackage

/* src/sfu_if.sv */
// Interfaces: input item channel and result item channel.
interface sfu_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] other_x;
	logic [31:0] other_y;
	modport source (output valid, pos_x, pos_y, other_x, other_y, input ready);
	modport sink   (input valid, pos_x, pos_y, other_x, other_y, output ready);
endinterface

interface sfu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] force_x;
	logic [31:0] force_y;
	logic        force_valid;
	modport source (output valid, force_x, force_y, force_valid, input ready);
	modport sink   (input valid, force_x, force_y, force_valid, output ready);
endinterface

/* src/sfu_cfg.sv */
// Configuration registers behind the APB-style port.
module sfu_cfg import sfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);
	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k        <= K_W'(1 << FRAC_BITS);
			cfg_q.rest     <= K_W'(1 << FRAC_BITS);
			cfg_q.mode     <= MODE_PAIR;
			cfg_q.anchor_x <= '0;
			cfg_q.anchor_y <= '0;
		end else if (wr) begin
			case (idx)
				REG_K:    cfg_q.k        <= pwdata[K_W-1:0];
				REG_REST: cfg_q.rest     <= pwdata[K_W-1:0];
				REG_MODE: cfg_q.mode     <= pwdata[1:0];
				REG_AX:   cfg_q.anchor_x <= pwdata;
				REG_AY:   cfg_q.anchor_y <= pwdata;
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_K:    prdata = 32'(cfg_q.k);
			REG_REST: prdata = 32'(cfg_q.rest);
			REG_MODE: prdata = 32'(cfg_q.mode);
			REG_AX:   prdata = cfg_q.anchor_x;
			REG_AY:   prdata = cfg_q.anchor_y;
			default:  prdata = '0;
		endcase
	end
endmodule

/* src/sfu_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module sfu_isqrt import sfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [SQ_W-1:0]   rad,
	output logic              out_vld,
	output logic [ROOT_W-1:0] root
);
	logic              vld_s  [SQ_ST];
	logic [SQ_W-1:0]   rad_s  [SQ_ST];
	logic [ROOT_W-1:0] root_s [SQ_ST];
	logic [REM_W-1:0]  rem_s  [SQ_ST];

	for (genvar i = 0; i < SQ_ST; i++) begin : g_st
		logic              vld_i;
		logic [SQ_W-1:0]   rad_i;
		logic [ROOT_W-1:0] root_i;
		logic [REM_W-1:0]  rem_i;
		logic [REM_W+1:0]  acc;
		logic [REM_W+1:0]  trial;

		if (i == 0) begin : g_first
			assign vld_i  = in_vld;
			assign rad_i  = rad;
			assign root_i = '0;
			assign rem_i  = '0;
		end else begin : g_next
			assign vld_i  = vld_s[i-1];
			assign rad_i  = rad_s[i-1];
			assign root_i = root_s[i-1];
			assign rem_i  = rem_s[i-1];
		end

		assign acc   = {rem_i, rad_i[SQ_W-1 -: 2]};
		assign trial = (REM_W+2)'({root_i, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i] <= rad_i << 2;
				if (acc >= trial) begin
					rem_s[i]  <= REM_W'(acc - trial);
					root_s[i] <= {root_i[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= REM_W'(acc);
					root_s[i] <= {root_i[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[SQ_ST-1];
	assign root    = root_s[SQ_ST-1];
endmodule

/* src/sfu_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module sfu_div import sfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [DIVN_W-1:0] num,
	input  logic [ROOT_W-1:0] den,
	output logic              out_vld,
	output logic [U_W-1:0]    quo
);
	logic              vld_s [DV_ST];
	logic [DIVN_W-1:0] rem_s [DV_ST];
	logic [ROOT_W-1:0] den_s [DV_ST];
	logic [U_W-1:0]    quo_s [DV_ST];

	for (genvar i = 0; i < DV_ST; i++) begin : g_st
		logic              vld_i;
		logic [DIVN_W-1:0] rem_i;
		logic [ROOT_W-1:0] den_i;
		logic [U_W-1:0]    quo_i;
		logic [DIVN_W-1:0] shd;

		if (i == 0) begin : g_first
			assign vld_i = in_vld;
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
		end else begin : g_next
			assign vld_i = vld_s[i-1];
			assign rem_i = rem_s[i-1];
			assign den_i = den_s[i-1];
			assign quo_i = quo_s[i-1];
		end

		assign shd = DIVN_W'(den_i) << (DV_ST - 1 - i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i] <= den_i;
				if (rem_i >= shd) begin
					rem_s[i] <= rem_i - shd;
					quo_s[i] <= {quo_i[U_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= rem_i;
					quo_s[i] <= {quo_i[U_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[DV_ST-1];
	assign quo     = quo_s[DV_ST-1];
endmodule

/* src/spring_force_unit_2d_top.sv */
// Top level: 2D Hooke spring force pipeline with its configuration port.
//
// One item enters every clock cycle while req.ready is high, and its result
// passes 3 front stages, 33 square-root stages, 3 stages for the length
// checks and the spring magnitude, 17 divider stages and 2 stages for the
// final product and saturation. The latency is set by the bit-per-stage square
// root and the bit-per-stage divider that forms the unit vector. The whole
// pipe holds together when the result item is not taken, so req.ready
// drops only while a finished result waits and the sink is not ready. When
// the length is tiny or a bungee spring is slack, force_valid is 0 and the
// force fields are 0. Write the registers only while the pipe is empty.
module spring_force_unit_2d_top import sfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sfu_in_if.sink            req,
	sfu_out_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	cfg_t cfg;
	logic en;

	sfu_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	function automatic logic [31:0] sat_force(input logic [FW-1:0] f, input logic neg);
		logic [FW-1:0] lim;
		logic [FW-1:0] q;
		lim = neg ? FW'(33'h0_8000_0000) : FW'(33'h0_7FFF_FFFF);
		q   = (f > lim) ? lim : f;
		return neg ? 32'(FW'(0) - q) : q[31:0];
	endfunction

	// Output register
	logic        vld_s8;
	logic [31:0] fx_s8;
	logic [31:0] fy_s8;
	logic        fv_s8;

	// Advance the whole pipe unless a finished result is stalled.
	assign en        = !vld_s8 || rsp.ready;
	assign req.ready = en;

	// S1: delta against the other endpoint or the anchor, split into sign and magnitude
	logic        vld_s1;
	geo_t        geo_s1;
	logic [31:0] ox, oy;
	logic [D_W-1:0] dx, dy;

	assign ox = (cfg.mode == MODE_ANCHOR) ? cfg.anchor_x : req.other_x;
	assign oy = (cfg.mode == MODE_ANCHOR) ? cfg.anchor_y : req.other_y;
	assign dx = {req.pos_x[31], req.pos_x} - {ox[31], ox};
	assign dy = {req.pos_y[31], req.pos_y} - {oy[31], oy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.ax     <= dx[D_W-1] ? (~dx + 1'b1) : dx;
			geo_s1.ay     <= dy[D_W-1] ? (~dy + 1'b1) : dy;
			geo_s1.sx     <= dx[D_W-1];
			geo_s1.sy     <= dy[D_W-1];
			geo_s1.k      <= cfg.k;
			geo_s1.rest   <= cfg.rest;
			geo_s1.bungee <= (cfg.mode == MODE_BUNGEE);
		end
	end

	// S2: squares, S3: their sum
	logic            vld_s2, vld_s3;
	geo_t            geo_s2, geo_s3;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= geo_s1.ax * geo_s1.ax;
			sqy_s2 <= geo_s1.ay * geo_s1.ay;
			geo_s2 <= geo_s1;
			sum_s3 <= sqx_s2 + sqy_s2;
			geo_s3 <= geo_s2;
		end
	end

	// Square root; the geometry rides alongside on a shift line.
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	geo_t              geo_sq [SQ_ST];

	sfu_isqrt u_isqrt (
		.clk, .arst_n, .en, .in_vld(vld_s3), .rad(sum_s3), .out_vld(sq_vld), .root(sq_root)
	);

	for (genvar i = 0; i < SQ_ST; i++) begin : g_geo
		always_ff @(posedge clk) begin
			if (en) begin
				geo_sq[i] <= (i == 0) ? geo_s3 : geo_sq[(i == 0) ? 0 : i-1];
			end
		end
	end

	// S4: tiny length, slack bungee, displacement from rest
	logic  vld_s4;
	chk_t  chk_s4;
	geo_t  ga;
	logic  lt_rest, le_rest;
	assign ga      = geo_sq[SQ_ST-1];
	assign lt_rest = sq_root < ROOT_W'(ga.rest);
	assign le_rest = sq_root <= ROOT_W'(ga.rest);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chk_s4.ax   <= ga.ax;
			chk_s4.ay   <= ga.ay;
			chk_s4.len  <= sq_root;
			chk_s4.dabs <= lt_rest ? (ROOT_W'(ga.rest) - sq_root) : (sq_root - ROOT_W'(ga.rest));
			chk_s4.k    <= ga.k;
			chk_s4.sx   <= ga.sx;
			chk_s4.sy   <= ga.sy;
			chk_s4.dneg <= lt_rest;
			chk_s4.skip <= (sq_root <= ROOT_W'(TINY_LEN)) || (ga.bungee && le_rest);
		end
	end

	// S5: k times |disp| in two partial products, S6: sum and scale
	logic                   vld_s5, vld_s6;
	chk_t                   chk_s5, chk_s6;
	logic [K_W+DL-1:0]      pkl_s5;
	logic [PK_W-DL-1:0]     pkh_s5;
	logic [MAG_W-1:0]       mag_s6;
	logic [PK_W-1:0]        pk_sum;

	assign pk_sum = PK_W'(pkl_s5) + (PK_W'(pkh_s5) << DL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pkl_s5 <= chk_s4.k * chk_s4.dabs[DL-1:0];
			pkh_s5 <= chk_s4.k * chk_s4.dabs[DABS_W-1:DL];
			chk_s5 <= chk_s4;
			mag_s6 <= MAG_W'(pk_sum >> FRAC_BITS);
			chk_s6 <= chk_s5;
		end
	end

	// Unit vector: |D| * 2^FRAC_BITS / length for each component.
	logic           dvx_vld, dvy_vld;
	logic [U_W-1:0] ux, uy;
	frc_t           frc_dv [DV_ST];
	frc_t           frc_in;

	assign frc_in = '{mag: mag_s6, dneg: chk_s6.dneg, sx: chk_s6.sx, sy: chk_s6.sy,
		skip: chk_s6.skip};

	sfu_div u_div_x (
		.clk, .arst_n, .en, .in_vld(vld_s6), .num({chk_s6.ax, FRAC_BITS'(0)}),
		.den(chk_s6.len), .out_vld(dvx_vld), .quo(ux)
	);

	sfu_div u_div_y (
		.clk, .arst_n, .en, .in_vld(vld_s6), .num({chk_s6.ay, FRAC_BITS'(0)}),
		.den(chk_s6.len), .out_vld(dvy_vld), .quo(uy)
	);

	for (genvar i = 0; i < DV_ST; i++) begin : g_frc
		always_ff @(posedge clk) begin
			if (en) begin
				frc_dv[i] <= (i == 0) ? frc_in : frc_dv[(i == 0) ? 0 : i-1];
			end
		end
	end

	// S7: magnitude times unit vector in two partial products
	logic                  vld_s7;
	frc_t                  frc_s7;
	frc_t                  fb;
	logic [ML+U_W-1:0]     pxl_s7, pyl_s7;
	logic [MAG_W-ML+U_W-1:0] pxh_s7, pyh_s7;
	assign fb = frc_dv[DV_ST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= dvx_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxl_s7 <= fb.mag[ML-1:0] * ux;
			pxh_s7 <= fb.mag[MAG_W-1:ML] * ux;
			pyl_s7 <= fb.mag[ML-1:0] * uy;
			pyh_s7 <= fb.mag[MAG_W-1:ML] * uy;
			frc_s7 <= fb;
		end
	end

	// S8: sum, scale, sign and saturate into the output register
	logic [P_W-1:0] prx, pry;
	logic           negx, negy;
	assign prx  = P_W'(pxl_s7) + (P_W'(pxh_s7) << ML);
	assign pry  = P_W'(pyl_s7) + (P_W'(pyh_s7) << ML);
	assign negx = !(frc_s7.dneg ^ frc_s7.sx);
	assign negy = !(frc_s7.dneg ^ frc_s7.sy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s8 <= frc_s7.skip ? '0 : sat_force(FW'(prx >> FRAC_BITS), negx);
			fy_s8 <= frc_s7.skip ? '0 : sat_force(FW'(pry >> FRAC_BITS), negy);
			fv_s8 <= !frc_s7.skip;
		end
	end

	assign rsp.valid       = vld_s8;
	assign rsp.force_x     = fx_s8;
	assign rsp.force_y     = fy_s8;
	assign rsp.force_valid = fv_s8;

	// Both dividers run in lockstep.
	a_div_lock: assert property (@(posedge clk) disable iff (!arst_n)
		dvx_vld == dvy_vld)
		else $error("divider valid bits disagree");

	// A skipped force carries zero fields.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.force_valid |-> rsp.force_x == 32'd0 && rsp.force_y == 32'd0)
		else $error("skipped force with nonzero fields");

	// A stalled result holds the input side.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input taken while result stalled");

	// An accepted item reaches the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_s1)
		else $error("accepted item lost at entry");
endmodule
